// ----- sv/cbis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbis_pkg;
    localparam int MaxNestDepth = 16;
    localparam int CountW = 33;
    localparam int LenW = 32;

    localparam logic [2:0] ST_MORE    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_DEEP    = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    localparam logic [2:0] MT_BSTR   = 3'd2;
    localparam logic [2:0] MT_TSTR   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] AI_MASK        = 5'h1F;
    localparam logic [4:0] AI_SIMPLE_LO   = 5'd20;
    localparam logic [4:0] AI_SIMPLE_HI   = 5'd23;
    localparam logic [4:0] AI_ONE_BYTE    = 5'd24;
    localparam logic [4:0] AI_TWO_BYTES   = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTES  = 5'd26;
    localparam logic [4:0] AI_EIGHT_BYTES = 5'd27;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
    localparam logic [LenW-1:0] LEN_MAX = {LenW{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE, PH_HEAD, PH_ARG, PH_PAYLOAD
    } t_phase;

    // command from the control unit to every stack cell
    typedef struct packed {
        logic             clear;  // start of item: all levels closed
        logic             push;   // open a level at the top
        logic [CountW-1:0] count; // count for the pushed level
        logic             done;   // an element ended: decrement and unwind
    } t_stack_cmd;
endpackage
`default_nettype wire

// ----- sv/cbis_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface cbis_in_if;
    logic       valid;
    logic       ready;
    logic       start_item;
    logic [7:0] data_byte;
    logic       end_of_buffer;
    modport source(output valid, start_item, data_byte, end_of_buffer, input ready);
    modport sink(input valid, start_item, data_byte, end_of_buffer, output ready);
endinterface

interface cbis_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] consumed_bytes;
    modport source(output valid, status, consumed_bytes, input ready);
    modport sink(input valid, status, consumed_bytes, output ready);
endinterface
`default_nettype wire

// ----- sv/cbis_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One nesting level. Active cells form a contiguous prefix; the top is the
// active cell whose upper neighbor is inactive.
module cbis_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire cbis_pkg::t_stack_cmd    i_cmd,
    input  wire logic                    i_below_act,  // lower neighbor active (1 for level 0)
    input  wire logic                    i_above_act,  // upper neighbor active
    input  wire logic                    i_above_pop,  // upper neighbor unwinds this cycle
    output logic                         o_act,
    output logic                         o_pop         // this level closes on done
);
    logic                              r_act;
    logic [cbis_pkg::CountW-1:0]       r_cnt;
    logic                              r_one;
    logic                              act_eff;
    logic                              is_top;
    logic                              dec;
    logic                              push_here;

    // a clear closes every level before a push in the same transfer
    assign act_eff = r_act && !i_cmd.clear;
    assign is_top = act_eff && !i_above_act;
    // decremented when it is the top, or the level above closes
    assign dec = i_cmd.done && act_eff && (is_top || i_above_pop);
    assign push_here = i_cmd.push && !act_eff && i_below_act;
    assign o_pop = dec && r_one;
    assign o_act = act_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (push_here) begin
            r_act <= 1'b1;
        end else if (i_cmd.clear || o_pop) begin
            r_act <= 1'b0;
        end
        if (push_here) begin
            r_cnt <= i_cmd.count;
            r_one <= (i_cmd.count == cbis_pkg::CountW'(1));
        end else if (dec) begin
            r_cnt <= r_cnt - cbis_pkg::CountW'(1);
            r_one <= (r_cnt == cbis_pkg::CountW'(2));
        end
    end
endmodule
`default_nettype wire

// ----- sv/cbis_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbis_stack #(
    parameter int DEPTH = cbis_pkg::MaxNestDepth
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cbis_pkg::t_stack_cmd i_cmd,
    output logic                      o_full,
    output logic                      o_unwound   // done empties the stack
);
    // act[g+1] is level g; act[0] stands below level 0
    logic [DEPTH:0]   act;
    logic [DEPTH-1:0] pop;

    assign act[0] = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic above_act;
        logic above_pop;
        if (g + 1 < DEPTH) begin : g_lnk
            assign above_act = act[g+2];
            assign above_pop = pop[g+1];
        end else begin : g_top
            assign above_act = 1'b0;
            assign above_pop = 1'b0;
        end
        cbis_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
            .i_below_act(act[g]),
            .i_above_act(above_act),
            .i_above_pop(above_pop),
            .o_act(act[g+1]), .o_pop(pop[g])
        );
    end

    assign o_full = act[DEPTH];
    // empty stack, or bottom level closes
    assign o_unwound = !act[1] || pop[0];
endmodule
`default_nettype wire

// ----- sv/cbor_item_skipper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// CBOR item skipper: accepts one encoded byte per cycle, back to back, and
// returns one status per byte (needs more, complete, truncated, malformed,
// too deep, ignored) with the count of item bytes so far. A chain of
// MAX_NEST_DEPTH nesting cells with per-level count-is-one flags unwinds any
// number of closing containers in the cycle the closing byte is taken.
// Results sit in one output register; a stalled output blocks input.
module cbor_item_skipper_unit #(
    parameter int MAX_NEST_DEPTH = cbis_pkg::MaxNestDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbis_in_if.sink   i_in,
    cbis_out_if.source o_out
);
    cbis_pkg::t_phase           r_phase, n_phase;
    logic [2:0]                 r_major, n_major;
    logic [63:0]                r_acc, n_acc;
    logic [3:0]                 r_argleft, n_argleft;
    logic [31:0]                r_payleft, n_payleft;
    logic [31:0]                r_off, n_off;
    logic                       r_ovalid;
    logic [2:0]                 r_status, n_status;
    logic [31:0]                r_cons;
    cbis_pkg::t_stack_cmd       cmd;
    logic                       full, unwound;
    logic                       xfer;

    logic [2:0]  major;
    logic [4:0]  ai;
    logic [31:0] off0;
    logic        act_en;      // act on an argument
    logic [2:0]  act_major;
    logic [63:0] act_arg;
    logic        elem_done;
    logic [2:0]  st;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign xfer = i_in.valid && i_in.ready;
    assign major = i_in.data_byte[7:5];
    assign ai = i_in.data_byte[4:0] & cbis_pkg::AI_MASK;

    cbis_stack #(.DEPTH(MAX_NEST_DEPTH)) u_stack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .o_full(full), .o_unwound(unwound)
    );

    always_comb begin
        cbis_pkg::t_phase ph;
        ph = i_in.start_item ? cbis_pkg::PH_HEAD : r_phase;
        off0 = i_in.start_item ? 32'd0 : r_off;
        n_phase = r_phase;
        n_major = r_major;
        n_acc = r_acc;
        n_argleft = r_argleft;
        n_payleft = r_payleft;
        n_off = r_off;
        n_status = cbis_pkg::ST_MORE;
        cmd = '0;
        cmd.clear = xfer && i_in.start_item;
        act_en = 1'b0;
        act_major = r_major;
        act_arg = '0;
        elem_done = 1'b0;
        st = cbis_pkg::ST_MORE;
        if (ph == cbis_pkg::PH_IDLE) begin
            n_status = cbis_pkg::ST_IGNORED;
        end else begin
            n_off = (off0 == cbis_pkg::LEN_MAX) ? off0 : off0 + 32'd1;
            n_phase = ph;
            unique case (ph)
                cbis_pkg::PH_ARG: begin
                    n_acc = {r_acc[55:0], i_in.data_byte};
                    n_argleft = r_argleft - 4'd1;
                    act_en = (n_argleft == 4'd0);
                    act_arg = n_acc;
                end
                cbis_pkg::PH_PAYLOAD: begin
                    n_payleft = r_payleft - 32'd1;
                    elem_done = (n_payleft == 32'd0);
                end
                default: begin
                    if (major == cbis_pkg::MT_SIMPLE) begin
                        if (ai >= cbis_pkg::AI_SIMPLE_LO && ai <= cbis_pkg::AI_SIMPLE_HI) begin
                            elem_done = 1'b1;
                        end else if (ai >= cbis_pkg::AI_TWO_BYTES
                                     && ai <= cbis_pkg::AI_EIGHT_BYTES) begin
                            n_payleft = 32'd1 << (ai - cbis_pkg::AI_ONE_BYTE);
                            n_phase = cbis_pkg::PH_PAYLOAD;
                        end else begin
                            st = cbis_pkg::ST_BAD;
                        end
                    end else if (ai < cbis_pkg::AI_ONE_BYTE) begin
                        act_en = 1'b1;
                        act_major = major;
                        act_arg = {59'd0, ai};
                    end else if (ai <= cbis_pkg::AI_EIGHT_BYTES) begin
                        n_major = major;
                        n_acc = '0;
                        n_argleft = 4'd1 << (ai - cbis_pkg::AI_ONE_BYTE);
                        n_phase = cbis_pkg::PH_ARG;
                    end else begin
                        st = cbis_pkg::ST_BAD;
                    end
                end
            endcase
            if (act_en) begin
                case (act_major) inside
                    cbis_pkg::MT_BSTR, cbis_pkg::MT_TSTR: begin
                        if (act_arg == 64'd0) begin
                            elem_done = 1'b1;
                        end else begin
                            n_payleft = (act_arg[63:32] != 32'd0) ? cbis_pkg::LEN_MAX
                                                                  : act_arg[31:0];
                            n_phase = cbis_pkg::PH_PAYLOAD;
                        end
                    end
                    cbis_pkg::MT_ARRAY, cbis_pkg::MT_MAP, cbis_pkg::MT_TAG: begin
                        if (act_major != cbis_pkg::MT_TAG && act_arg == 64'd0) begin
                            elem_done = 1'b1;
                        end else if (full) begin
                            st = cbis_pkg::ST_DEEP;
                        end else begin
                            cmd.push = xfer;
                            n_phase = cbis_pkg::PH_HEAD;
                            if (act_major == cbis_pkg::MT_TAG) begin
                                cmd.count = cbis_pkg::CountW'(1);
                            end else if (act_major == cbis_pkg::MT_ARRAY) begin
                                cmd.count = (act_arg[63:33] != 31'd0) ? cbis_pkg::COUNT_MAX
                                                                      : act_arg[32:0];
                            end else begin
                                cmd.count = (act_arg[63:32] != 32'd0) ? cbis_pkg::COUNT_MAX
                                                                      : {act_arg[31:0], 1'b0};
                            end
                        end
                    end
                    default: elem_done = 1'b1;
                endcase
            end
            if (elem_done) begin
                cmd.done = xfer;
                n_phase = cbis_pkg::PH_HEAD;
                st = unwound ? cbis_pkg::ST_DONE : cbis_pkg::ST_MORE;
            end
            if (st != cbis_pkg::ST_MORE) begin
                n_phase = cbis_pkg::PH_IDLE;
            end else if (i_in.end_of_buffer) begin
                st = cbis_pkg::ST_TRUNC;
                n_phase = cbis_pkg::PH_IDLE;
            end
            n_status = st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cbis_pkg::PH_IDLE;
            r_ovalid <= 1'b0;
            r_off <= '0;
        end else begin
            if (xfer) begin
                r_phase <= n_phase;
                r_off <= n_off;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (xfer) begin
            r_major <= n_major;
            r_acc <= n_acc;
            r_argleft <= n_argleft;
            r_payleft <= n_payleft;
            r_status <= n_status;
            r_cons <= (n_status == cbis_pkg::ST_IGNORED) ? 32'd0 : n_off;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.status = r_status;
    assign o_out.consumed_bytes = r_cons;
endmodule
`default_nettype wire

// ----- sv/cbis_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbis_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_start,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_status,
    input wire logic [31:0] i_out_cons
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status <= cbis_pkg::ST_IGNORED)
        else $error("status out of range");
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == cbis_pkg::ST_IGNORED) |-> i_out_cons == 32'd0)
        else $error("ignored byte with count");
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_start) |=> (i_out_valid && i_out_cons == 32'd1))
        else $error("start byte count not one");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("transfer without result");
endmodule

bind cbor_item_skipper_unit cbis_checker u_cbis_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready), .i_in_start(i_in.start_item),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_status(o_out.status), .i_out_cons(o_out.consumed_bytes)
);
`default_nettype wire

// ----- test/cbor_item_skipper_unit_tb.sv -----
`timescale 1ns / 1ps
module cbor_item_skipper_unit_tb;
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] consumed;
    } t_status_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbis_in_if  in_if();
    cbis_out_if out_if();

    cbor_item_skipper_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if),
        .o_out(out_if)
    );

    always #5 i_clk = ~i_clk;

    t_status_rec status_q[$];
    logic [7:0]  byte_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;

    // skipper state mirror
    cbis_pkg::t_phase  phase;
    logic [2:0]        arg_major;
    logic [63:0]       arg_acc;
    logic [3:0]        arg_left;
    logic [31:0]       payload_left;
    logic [cbis_pkg::CountW-1:0] nest_count[cbis_pkg::MaxNestDepth];
    int                nest_level;
    logic [31:0]       item_offset;

    function automatic logic [2:0] close_element();
        phase = cbis_pkg::PH_HEAD;
        while (nest_level > 0) begin
            nest_count[nest_level-1] = nest_count[nest_level-1] - 1'b1;
            if (nest_count[nest_level-1] != '0) return cbis_pkg::ST_MORE;
            nest_level--;
        end
        return cbis_pkg::ST_DONE;
    endfunction

    function automatic logic [2:0] open_nesting(logic [cbis_pkg::CountW-1:0] cnt);
        if (nest_level >= cbis_pkg::MaxNestDepth) return cbis_pkg::ST_DEEP;
        nest_count[nest_level] = cnt;
        nest_level++;
        phase = cbis_pkg::PH_HEAD;
        return cbis_pkg::ST_MORE;
    endfunction

    function automatic logic [2:0] apply_argument(logic [2:0] major, logic [63:0] arg);
        case (major) inside
            cbis_pkg::MT_BSTR, cbis_pkg::MT_TSTR: begin
                if (arg == 0) return close_element();
                payload_left = (arg > {32'd0, cbis_pkg::LEN_MAX}) ? cbis_pkg::LEN_MAX
                                                                  : arg[31:0];
                phase = cbis_pkg::PH_PAYLOAD;
                return cbis_pkg::ST_MORE;
            end
            cbis_pkg::MT_ARRAY: begin
                if (arg == 0) return close_element();
                return open_nesting((arg > {31'd0, cbis_pkg::COUNT_MAX}) ? cbis_pkg::COUNT_MAX
                                                                         : arg[32:0]);
            end
            cbis_pkg::MT_MAP: begin
                if (arg == 0) return close_element();
                return open_nesting((arg > {32'd0, cbis_pkg::COUNT_MAX[32:1]})
                                    ? cbis_pkg::COUNT_MAX : {arg[31:0], 1'b0});
            end
            cbis_pkg::MT_TAG: return open_nesting(33'd1);
            default: return close_element();
        endcase
    endfunction

    function automatic logic [2:0] decode_head(logic [7:0] b);
        logic [2:0] major;
        logic [4:0] ai;
        major = b[7:5];
        ai = b[4:0] & cbis_pkg::AI_MASK;
        if (major == cbis_pkg::MT_SIMPLE) begin
            if (ai >= cbis_pkg::AI_SIMPLE_LO && ai <= cbis_pkg::AI_SIMPLE_HI)
                return close_element();
            if (ai >= cbis_pkg::AI_TWO_BYTES && ai <= cbis_pkg::AI_EIGHT_BYTES) begin
                payload_left = 32'd1 << (ai - cbis_pkg::AI_ONE_BYTE);
                phase = cbis_pkg::PH_PAYLOAD;
                return cbis_pkg::ST_MORE;
            end
            return cbis_pkg::ST_BAD;
        end
        if (ai < cbis_pkg::AI_ONE_BYTE) return apply_argument(major, {59'd0, ai});
        if (ai <= cbis_pkg::AI_EIGHT_BYTES) begin
            arg_major = major;
            arg_acc = '0;
            arg_left = 4'd1 << (ai - cbis_pkg::AI_ONE_BYTE);
            phase = cbis_pkg::PH_ARG;
            return cbis_pkg::ST_MORE;
        end
        return cbis_pkg::ST_BAD;
    endfunction

    function automatic t_status_rec predict_status(logic s, logic [7:0] b, logic e);
        t_status_rec r;
        logic [2:0] st;
        if (s) begin
            nest_level = 0;
            item_offset = '0;
            phase = cbis_pkg::PH_HEAD;
        end else if (phase == cbis_pkg::PH_IDLE) begin
            r.status = cbis_pkg::ST_IGNORED;
            r.consumed = '0;
            return r;
        end
        if (item_offset != 32'hFFFF_FFFF) item_offset++;
        case (phase)
            cbis_pkg::PH_ARG: begin
                arg_acc = {arg_acc[55:0], b};
                arg_left = arg_left - 1'b1;
                st = (arg_left == 0) ? apply_argument(arg_major, arg_acc) : cbis_pkg::ST_MORE;
            end
            cbis_pkg::PH_PAYLOAD: begin
                payload_left = payload_left - 1'b1;
                st = (payload_left == 0) ? close_element() : cbis_pkg::ST_MORE;
            end
            default: st = decode_head(b);
        endcase
        if (st != cbis_pkg::ST_MORE) begin
            phase = cbis_pkg::PH_IDLE;
        end else if (e) begin
            st = cbis_pkg::ST_TRUNC;
            phase = cbis_pkg::PH_IDLE;
        end
        r.status = st;
        r.consumed = item_offset;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = cbis_pkg::PH_IDLE;
            nest_level = 0;
            item_offset = '0;
            arg_left = '0;
            payload_left = '0;
        end else if (in_if.valid && in_if.ready) begin
            status_q.push_back(predict_status(in_if.start_item, in_if.data_byte,
                                              in_if.end_of_buffer));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d consumed=%0d", $time,
                         out_if.status, out_if.consumed_bytes);
                errors++;
            end else begin
                t_status_rec x;
                x = status_q.pop_front();
                if (x.status !== out_if.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, x.status,
                             out_if.status);
                    errors++;
                end
                if (x.consumed !== out_if.consumed_bytes) begin
                    $display("%0t: consumed_bytes expected %0d actual %0d", $time,
                             x.consumed, out_if.consumed_bytes);
                    errors++;
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= !stalls_on || (gap_len() == 0);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(logic s, logic [7:0] b, logic e);
        int g;
        g = gaps_on ? gap_len() : 0;
        if (g > 0) begin
            in_if.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.start_item = s;
        in_if.data_byte = b;
        in_if.end_of_buffer = e;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // send byte_q as one buffer; end_of_buffer on its last byte when asked
    task automatic send_buffer(bit eob_last);
        for (int i = 0; i < byte_q.size(); i++)
            send_byte(i == 0, byte_q[i], eob_last && i == byte_q.size() - 1);
        byte_q.delete();
    endtask

    task automatic drain();
        in_if.valid = 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic void put_head(int major, logic [63:0] arg);
        int w;
        if (arg < 24 && $urandom_range(0, 3) != 0) begin
            byte_q.push_back({major[2:0], arg[4:0]});
            return;
        end
        w = (arg < 256) ? 0 : (arg < 65536) ? 1 : (arg < 64'h1_0000_0000) ? 2 : 3;
        if ($urandom_range(0, 4) == 0) w = $urandom_range(w, 3);
        byte_q.push_back({major[2:0], 5'(24 + w)});
        for (int i = (1 << w) - 1; i >= 0; i--) byte_q.push_back(arg[8*i +: 8]);
    endfunction

    function automatic void put_item(int lvl);
        int k;
        int n;
        k = (lvl > 4) ? $urandom_range(0, 2) : $urandom_range(0, 9);
        if (k == 2 && lvl > 4) k = 6;
        case (k)
            0, 1: put_head(k, $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                        : 64'($urandom_range(0, 300)));
            2: begin
                n = $urandom_range(0, 6);
                put_head($urandom_range(2, 3), 64'(n));
                repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
                n = $urandom_range(0, 3);
                put_head(4, 64'(n));
                repeat (n) put_item(lvl + 1);
            end
            4: begin
                n = $urandom_range(0, 2);
                put_head(5, 64'(n));
                repeat (2 * n) put_item(lvl + 1);
            end
            5: begin
                put_head(6, 64'($urandom_range(0, 40)));
                put_item(lvl + 1);
            end
            7: begin
                n = $urandom_range(25, 27);
                byte_q.push_back({3'd7, 5'(n)});
                repeat (1 << (n - 24)) byte_q.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
                if (lvl == 0 && $urandom_range(0, 3) == 0) begin
                    n = $urandom_range(14, 18);
                    repeat (n) byte_q.push_back(8'h81);
                    byte_q.push_back(8'h00);
                end else begin
                    byte_q.push_back(8'hF4 + 8'($urandom_range(0, 3)));
                end
            end
            default: byte_q.push_back(8'hF4 + 8'($urandom_range(0, 3)));
        endcase
    endfunction

    task automatic send_bytes(logic [7:0] b[$], bit eob_last);
        byte_q = b;
        send_buffer(eob_last);
    endtask

    task automatic test_heads();
        send_bytes('{8'h00}, 0);
        send_bytes('{8'h17}, 1);
        send_bytes('{8'h18, 8'hFF}, 0);
        send_bytes('{8'h39, 8'h12, 8'h34}, 0);
        send_bytes('{8'h1A, 8'hDE, 8'hAD, 8'hBE, 8'hEF}, 0);
        send_bytes('{8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
        send_bytes('{8'hF4}, 0);
        send_bytes('{8'hF7}, 0);
        send_bytes('{8'hF9, 8'h3C, 8'h00}, 0);
        send_bytes('{8'hFA, 8'h01, 8'h02, 8'h03, 8'h04}, 0);
        send_bytes('{8'hFB, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08}, 0);
    endtask

    task automatic test_malformed();
        send_bytes('{8'h1C}, 0);
        send_bytes('{8'hFF}, 0);
        send_bytes('{8'hF0}, 0);
        send_bytes('{8'hF8}, 0);
        send_bytes('{8'h9F}, 0);
    endtask

    task automatic test_containers();
        send_bytes('{8'h40}, 0);
        send_bytes('{8'h60}, 0);
        send_bytes('{8'h80}, 0);
        send_bytes('{8'hA0}, 0);
        send_bytes('{8'hA1, 8'h01, 8'h62, 8'h61, 8'h62}, 0);
        send_bytes('{8'hC1, 8'h82, 8'h81, 8'h00, 8'h00}, 0);
        byte_q.delete();
        repeat (16) byte_q.push_back(8'h81);
        byte_q.push_back(8'h00);
        send_buffer(0);
        repeat (17) byte_q.push_back(8'h81);
        send_buffer(0);
    endtask

    task automatic test_edges();
        send_byte(0, 8'hAA, 0);
        send_bytes('{8'h83, 8'h01}, 0);
        send_bytes('{8'h00}, 0);
        send_bytes('{8'h82, 8'h01}, 1);
        send_bytes('{8'h9B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00}, 1);
        send_bytes('{8'h5B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00}, 1);
    endtask

    task automatic test_pause();
        send_bytes('{8'hA1, 8'h00}, 0);
        drain();
        send_bytes('{8'h00}, 0);
    endtask

    task automatic test_random(int target);
        int sent;
        int r;
        int cut;
        sent = 0;
        while (sent < target) begin
            if (sent > target / 3 && sent < target / 2) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on = 1'b1;
                stalls_on = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                put_item(0);
                if (r < 20 && byte_q.size() > 1) begin
                    cut = $urandom_range(1, byte_q.size() - 1);
                    while (byte_q.size() > cut) void'(byte_q.pop_back());
                    sent += byte_q.size();
                    send_buffer(r < 16);
                end else begin
                    sent += byte_q.size();
                    send_buffer(r < 30);
                end
            end
        end
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.start_item = 1'b0;
        in_if.data_byte = '0;
        in_if.end_of_buffer = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_heads();
        test_malformed();
        test_containers();
        test_edges();
        test_pause();
        test_random(1100);
        drain();
        repeat (5) @(posedge i_clk);
        if (errors == 0 && status_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- files.f -----
sv/cbis_pkg.sv
sv/cbis_if.sv
sv/cbis_cell.sv
sv/cbis_stack.sv
sv/cbor_item_skipper_unit.sv
sv/cbis_checker.sv
test/cbor_item_skipper_unit_tb.sv
